/* src/mtm_pkg.sv */
// types and constants shared by the transition matrix builder
// no dependencies
package mtm_pkg;

    localparam int SYM_W       = 8;
    localparam int TABLE_SLOTS = 8;
    localparam int NS_W        = 4;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int POS_W       = 3;
    localparam int FRAC_W      = 16;
    localparam int PROB_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_SYMBOLS = 1'd1;

    localparam logic [NS_W-1:0]   NUM_STATES_RESET = 4'd4;
    localparam logic [CFG_W-1:0]  SYMBOLS_RESET    = 64'h0000_0000_5447_4341;
    localparam logic [PROB_W-1:0] PROB_ONE         = 17'h1_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_UPD,
        S_SUM_RD,
        S_SUM_ACC,
        S_COL_RD,
        S_COL_CHK,
        S_DIV,
        S_OUT,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic accept_in;
        logic map_rd;
        logic upd;
        logic em_rd;
        logic rc_first;
        logic col_reset;
        logic col_next;
        logic row_next;
        logic sum_acc;
        logic div_start;
        logic out_load;
        logic clr_seq;
    } cmd_t;

    typedef struct packed {
        logic last_in;
        logic col_last;
        logic row_last;
        logic sum_zero;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

/* src/mtm_div.sv */
// restoring divider, one quotient bit per cycle, for (count << 16) / row sum
// depends on mtm_pkg
module mtm_div
    import mtm_pkg::*;
#(
    parameter int CW = 16,
    parameter int SW = 19
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CW-1:0]     dividend,
    input  logic [SW-1:0]     divisor,
    output logic [PROB_W-1:0] quotient,
    output logic              busy,
    output logic              done
);

    localparam int DW    = CW + FRAC_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]     dvd_reg;
    logic [SW-1:0]     div_reg;
    logic [SW-1:0]     rem_reg;
    logic [PROB_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SW:0]       trial;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DW-1]};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {dividend, {FRAC_W{1'b0}}};
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            rem_reg <= ge ? SW'(trial - {1'b0, div_reg}) : SW'(trial);
            quo_reg <= {quo_reg[PROB_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
`endif

endmodule

/* src/mtm_datapath.sv */
// datapath: configuration, symbol mapping, count store, row sums and output register
// depends on mtm_pkg and mtm_div
module mtm_datapath
    import mtm_pkg::*;
#(
    parameter int MAX_STATES  = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 last,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [POS_W-1:0]     row,
    output logic [POS_W-1:0]     col,
    output logic [PROB_W-1:0]    probability,
    output logic                 empty_row,
    output logic                 end_of_matrix,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int IDX_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int DEPTH  = MAX_STATES * MAX_STATES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = COUNT_WIDTH + IDX_W;
    localparam int SLOTS  = (MAX_STATES < TABLE_SLOTS) ? MAX_STATES : TABLE_SLOTS;

    logic [NS_W-1:0]        num_states_reg;
    logic [CFG_W-1:0]       symbols_reg;
    logic [SYM_W-1:0]       symbol_reg;
    logic                   last_reg;
    logic [IDX_W-1:0]       prev_reg;
    logic                   have_prev_reg;
    logic [IDX_W-1:0]       cur_reg;
    logic [ADDR_W-1:0]      wr_addr_reg;
    logic [IDX_W-1:0]       r_reg;
    logic [IDX_W-1:0]       c_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [DEPTH-1:0]       valid_reg;
    logic                   out_valid_reg;
    logic [POS_W-1:0]       row_reg;
    logic [POS_W-1:0]       col_reg;
    logic [PROB_W-1:0]      prob_reg;
    logic                   empty_reg;
    logic                   eom_reg;

    logic [COUNT_WIDTH-1:0] count_mem [DEPTH];

    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       cur_idx;
    logic [ADDR_W-1:0]      upd_addr;
    logic [ADDR_W-1:0]      em_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   rd_en;
    logic [COUNT_WIDTH-1:0] count_val;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   wr_en;
    logic [PROB_W-1:0]      quotient;
    logic                   div_busy;
    logic                   div_done;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg <= NUM_STATES_RESET;
            symbols_reg    <= SYMBOLS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_STATES:    num_states_reg <= cfg_data[NS_W-1:0];
                CFG_STATE_SYMBOLS: symbols_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // highest state index in use
    always_comb
    begin
        if (num_states_reg == '0)
            last_idx = '0;
        else if (int'(num_states_reg) > MAX_STATES)
            last_idx = IDX_W'(MAX_STATES - 1);
        else
            last_idx = IDX_W'(num_states_reg - 1'b1);
    end

    // highest matching table entry wins, otherwise keep the previous index
    always_comb
    begin
        cur_idx = prev_reg;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (IDX_W'(k) <= last_idx && symbols_reg[SYM_W*k +: SYM_W] == symbol_reg)
                cur_idx = IDX_W'(k);
        end
    end

    assign upd_addr  = ADDR_W'(prev_reg) * ADDR_W'(MAX_STATES) + ADDR_W'(cur_idx);
    assign em_addr   = ADDR_W'(r_reg) * ADDR_W'(MAX_STATES) + ADDR_W'(c_reg);
    assign rd_addr   = cmd.map_rd ? upd_addr : em_addr;
    assign rd_en     = cmd.map_rd || cmd.em_rd;
    assign count_val = rd_valid_reg ? rd_data_reg : '0;
    assign count_inc = (count_val == {COUNT_WIDTH{1'b1}}) ? count_val : count_val + 1'b1;
    assign wr_en     = cmd.upd && have_prev_reg;

    // count store
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= count_mem[rd_addr];
        if (wr_en)
            count_mem[wr_addr_reg] <= count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
            if (cmd.clr_seq)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr_reg] <= 1'b1;
        end
    end

    // request capture and mapping
    always_ff @(posedge clk)
    begin
        if (cmd.accept_in)
        begin
            symbol_reg <= symbol;
            last_reg   <= last;
        end
        if (cmd.map_rd)
        begin
            cur_reg     <= cur_idx;
            wr_addr_reg <= upd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (cmd.clr_seq)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (cmd.upd)
        begin
            prev_reg      <= cur_reg;
            have_prev_reg <= 1'b1;
        end
    end

    // matrix walk and row sum
    always_ff @(posedge clk)
    begin
        if (cmd.rc_first)
        begin
            r_reg   <= '0;
            c_reg   <= '0;
            sum_reg <= '0;
        end
        else if (cmd.row_next)
        begin
            r_reg   <= r_reg + 1'b1;
            c_reg   <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (cmd.col_reset)
                c_reg <= '0;
            else if (cmd.col_next)
                c_reg <= c_reg + 1'b1;
            if (cmd.sum_acc)
                sum_reg <= sum_reg + SUM_W'(count_val);
        end
    end

    mtm_div #(
        .CW (COUNT_WIDTH),
        .SW (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (count_val),
        .divisor  (sum_reg),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            row_reg   <= POS_W'(r_reg);
            col_reg   <= POS_W'(c_reg);
            prob_reg  <= (sum_reg == '0) ? '0 : quotient;
            empty_reg <= (sum_reg == '0);
            eom_reg   <= (r_reg == last_idx) && (c_reg == last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign row           = row_reg;
    assign col           = col_reg;
    assign probability   = prob_reg;
    assign empty_row     = empty_reg;
    assign end_of_matrix = eom_reg;

    always_comb
    begin
        sts.last_in  = last_reg;
        sts.col_last = (c_reg == last_idx);
        sts.row_last = (r_reg == last_idx);
        sts.sum_zero = (sum_reg == '0);
        sts.div_done = div_done && !div_busy;
        sts.out_free = !out_valid_reg || out_ready;
    end

`ifndef NO_ASSERTIONS
    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (prob_reg <= PROB_ONE))
        else $error("probability above one");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> (prob_reg == '0))
        else $error("empty row with non-zero probability");

    a_clear_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_seq |=> (!have_prev_reg && valid_reg == '0))
        else $error("sequence state not cleared");
`endif

endmodule

/* src/mtm_ctrl.sv */
// controller state machine: symbol update, row sums, division and emission
// depends on mtm_pkg
module mtm_ctrl
    import mtm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MAP;
            end
            S_MAP:
                state_next = S_UPD;
            S_UPD:
                state_next = sts.last_in ? S_SUM_RD : S_IDLE;
            S_SUM_RD:
                state_next = S_SUM_ACC;
            S_SUM_ACC:
                state_next = sts.col_last ? S_COL_RD : S_SUM_RD;
            S_COL_RD:
                state_next = S_COL_CHK;
            S_COL_CHK:
                state_next = sts.sum_zero ? S_OUT : S_DIV;
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    if (!sts.col_last)
                        state_next = S_COL_RD;
                    else if (sts.row_last)
                        state_next = S_CLEAR;
                    else
                        state_next = S_SUM_RD;
                end
            end
            S_CLEAR:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.accept_in = in_valid;
            end
            S_MAP:
                cmd.map_rd = 1'b1;
            S_UPD:
            begin
                cmd.upd      = 1'b1;
                cmd.rc_first = sts.last_in;
            end
            S_SUM_RD:
                cmd.em_rd = 1'b1;
            S_SUM_ACC:
            begin
                cmd.sum_acc   = 1'b1;
                cmd.col_reset = sts.col_last;
                cmd.col_next  = !sts.col_last;
            end
            S_COL_RD:
                cmd.em_rd = 1'b1;
            S_COL_CHK:
                cmd.div_start = !sts.sum_zero;
            S_DIV:
                ;
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.col_next = !sts.col_last;
                    cmd.row_next = sts.col_last && !sts.row_last;
                end
            end
            S_CLEAR:
                cmd.clr_seq = 1'b1;
            default:
                ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while occupied");

    a_no_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.sum_zero)
        else $error("division started on an empty row");

    a_accept_map: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept_in |=> (state_reg == S_MAP))
        else $error("accepted request not mapped");
`endif

endmodule

/* src/markov_transition_matrix_builder.sv */
// top level of the markov transition matrix builder
// depends on mtm_pkg, mtm_ctrl and mtm_datapath
//
// Input channel (in_valid/in_ready) takes one symbol byte per request with a
// last flag. Each symbol is mapped through the state_symbols table and the
// transition from the previous state is counted, saturating at the maximum.
// A symbol passes through capture, map and count read, then count write
// back in the count store; in_ready is high only while idle.
// A request with last set is counted and then starts emission of the
// row-normalised matrix in row-major order on the output channel
// (out_valid/out_ready). Per row the sum reads and accumulates each column,
// then each entry is read, divided by the bit-serial divider and loaded
// into the output register (an empty row skips the divider). The final
// entry carries end_of_matrix, after which counts and the previous state
// are cleared.
// A stalled receiver holds the output register and pauses emission; the
// last entry may still be waiting when the next symbol is accepted.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Reset clears all counts at once and loads num_states 4, symbols "ACGT".
module markov_transition_matrix_builder
    import mtm_pkg::*;
#(
    parameter int MAX_STATES  = 8,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     row,
    output logic [POS_W-1:0]     col,
    output logic [PROB_W-1:0]    probability,
    output logic                 empty_row,
    output logic                 end_of_matrix
);

    cmd_t cmd;
    sts_t sts;

    mtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtm_datapath #(
        .MAX_STATES  (MAX_STATES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .symbol        (symbol),
        .last          (last),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .row           (row),
        .col           (col),
        .probability   (probability),
        .empty_row     (empty_row),
        .end_of_matrix (end_of_matrix),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

/* verif/mtm_matrix_checker.sv */
// checker for the transition matrix builder: watches the config port and both channels,
// predicts every matrix entry and compares it with what comes out
// depends on mtm_pkg
`timescale 1ns / 100ps

module mtm_matrix_checker
    import mtm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 last,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [POS_W-1:0]     row,
    input  logic [POS_W-1:0]     col,
    input  logic [PROB_W-1:0]    probability,
    input  logic                 empty_row,
    input  logic                 end_of_matrix,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [PROB_W-1:0] prob;
        logic              empty;
        logic              eom;
    } matrix_entry_t;

    logic [15:0]      trans_count [TABLE_SLOTS][TABLE_SLOTS];
    logic [POS_W-1:0] prev_state;
    logic             have_prev;
    logic [NS_W-1:0]  num_states_reg;
    logic [CFG_W-1:0] symbol_table;
    matrix_entry_t    expected_entries [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic int effective_states();
        if (num_states_reg == 0)
            return 1;
        if (num_states_reg > TABLE_SLOTS)
            return TABLE_SLOTS;
        return int'(num_states_reg);
    endfunction

    task automatic clear_sequence();
        for (int r = 0; r < TABLE_SLOTS; r++)
            for (int c = 0; c < TABLE_SLOTS; c++)
                trans_count[r][c] = '0;
        prev_state = '0;
        have_prev  = 1'b0;
    endtask

    task automatic predict_request(input logic [SYM_W-1:0] sym, input logic lst);
        int               n;
        logic [POS_W-1:0] cur;
        logic [31:0]      row_sum;
        logic [31:0]      quotient;
        matrix_entry_t    e;
        n   = effective_states();
        cur = prev_state;
        for (int k = 0; k < n; k++)
            if (symbol_table[8*k +: 8] == sym)
                cur = k[POS_W-1:0];
        if (have_prev && trans_count[prev_state][cur] != 16'hFFFF)
            trans_count[prev_state][cur] = trans_count[prev_state][cur] + 16'd1;
        prev_state = cur;
        have_prev  = 1'b1;
        if (lst)
        begin
            for (int r = 0; r < n; r++)
            begin
                row_sum = 0;
                for (int c = 0; c < n; c++)
                    row_sum = row_sum + trans_count[r][c];
                for (int c = 0; c < n; c++)
                begin
                    quotient = 0;
                    if (row_sum != 0)
                        quotient = {trans_count[r][c], 16'h0000} / row_sum;
                    e.row   = r[POS_W-1:0];
                    e.col   = c[POS_W-1:0];
                    e.prob  = quotient[PROB_W-1:0];
                    e.empty = (row_sum == 0);
                    e.eom   = (r == n - 1) && (c == n - 1);
                    expected_entries.insert(expected_entries.size(), e);
                end
            end
            clear_sequence();
        end
    endtask

    task automatic check_entry();
        matrix_entry_t e;
        if (expected_entries.size() == 0)
        begin
            report_mismatch($sformatf("entry row %0d col %0d with nothing expected", row, col));
            return;
        end
        e = expected_entries.pop_front();
        if (row !== e.row)
            report_mismatch($sformatf("row got %0d expected %0d", row, e.row));
        if (col !== e.col)
            report_mismatch($sformatf("col got %0d expected %0d (row %0d)", col, e.col, e.row));
        if (probability !== e.prob)
            report_mismatch($sformatf("probability got %0d expected %0d at %0d,%0d",
                                      probability, e.prob, e.row, e.col));
        if (empty_row !== e.empty)
            report_mismatch($sformatf("empty_row got %b expected %b at %0d,%0d",
                                      empty_row, e.empty, e.row, e.col));
        if (end_of_matrix !== e.eom)
            report_mismatch($sformatf("end_of_matrix got %b expected %b at %0d,%0d",
                                      end_of_matrix, e.eom, e.row, e.col));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sequence();
            num_states_reg = NUM_STATES_RESET;
            symbol_table   = SYMBOLS_RESET;
            expected_entries.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_NUM_STATES)
                    num_states_reg = cfg_data[NS_W-1:0];
                else if (cfg_index == CFG_STATE_SYMBOLS)
                    symbol_table = cfg_data;
            end
            if (in_valid && in_ready)
                predict_request(symbol, last);
            if (out_valid && out_ready)
                check_entry();
            pending <= expected_entries.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// testbench top for the transition matrix builder: clock, reset, config writes and
// request stimulus with random idling; the verdict comes from mtm_matrix_checker
// depends on mtm_pkg, mtm_matrix_checker and the markov_transition_matrix_builder rtl
`timescale 1ns / 100ps

module tb_top;
    import mtm_pkg::*;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_NUM_STATES;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [SYM_W-1:0]     symbol        = '0;
    logic                 last          = 1'b0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic [PROB_W-1:0]    probability;
    logic                 empty_row;
    logic                 end_of_matrix;
    logic                 calm          = 1'b0;
    int                   fail_count;
    int                   pending;

    markov_transition_matrix_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .symbol        (symbol),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row           (row),
        .col           (col),
        .probability   (probability),
        .empty_row     (empty_row),
        .end_of_matrix (end_of_matrix)
    );

    mtm_matrix_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .symbol        (symbol),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row           (row),
        .col           (col),
        .probability   (probability),
        .empty_row     (empty_row),
        .end_of_matrix (end_of_matrix),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 32);

    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_symbol(input logic [SYM_W-1:0] s, input logic l);
        if (!calm)
            while ($urandom_range(99) < 32)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        symbol   <= s;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // wait until every expected entry is out and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] ns_word, input logic [CFG_W-1:0] syms);
        cfg_write <= 1'b1;
        cfg_index <= CFG_NUM_STATES;
        cfg_data  <= ns_word;
        @(posedge clk);
        cfg_index <= CFG_STATE_SYMBOLS;
        cfg_data  <= syms;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_syms;
        logic [CFG_W-1:0] ns_word;
        logic [SYM_W-1:0] s;
        logic             l;
        int               phase_ns;
        int               eff;
        int               seqs;
        int               len;
        int               slot;
        int               phase_no;
        int               random_items;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table "ACGT": unmatched first symbol falls to state 0, unmatched later reuses
        send_symbol(8'h5A, 1'b0);
        send_symbol(8'h43, 1'b0);
        send_symbol(8'h5A, 1'b0);
        send_symbol(8'h47, 1'b0);
        send_symbol(8'h54, 1'b0);
        send_symbol(8'h54, 1'b0);
        send_symbol(8'h41, 1'b1);
        // lone last request: every row empty
        send_symbol(8'h47, 1'b1);
        drain();

        // out-of-range count clamps to eight, duplicated symbol: highest slot wins
        write_config(64'd15, 64'hAA_FF_80_7F_41_41_01_00);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h41, 1'b0);
        send_symbol(8'h7F, 1'b0);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h41, 1'b1);
        drain();

        // zero count acts as one state
        write_config(64'd0, 64'h0000_0000_0000_0000);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'h00, 1'b1);
        drain();

        // count shrunk in the middle of a sequence
        write_config(64'd8, 64'hAA_FF_80_7F_41_41_01_00);
        send_symbol(8'hAA, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h01, 1'b0);
        drain();
        write_config(64'd2, 64'hAA_FF_80_7F_41_41_01_00);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'h00, 1'b1);
        drain();

        random_items = 0;
        phase_no = 0;
        while (random_items < 400)
        begin
            phase_ns   = ($urandom_range(1) == 1) ? $urandom_range(1, 8) : $urandom_range(0, 15);
            eff        = (phase_ns == 0) ? 1 : ((phase_ns > 8) ? 8 : phase_ns);
            phase_syms = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
            begin
                slot = $urandom_range(7);
                phase_syms[8*slot +: 8] = phase_syms[7:0];
            end
            ns_word = {$urandom, $urandom};
            ns_word[NS_W-1:0] = phase_ns[NS_W-1:0];
            write_config(ns_word, phase_syms);
            calm = (phase_no == 2);
            seqs = $urandom_range(2, 5);
            for (int q = 0; q < seqs; q++)
            begin
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(4) == 0)
                        s = SYM_W'($urandom_range(255));
                    else
                    begin
                        slot = $urandom_range(eff - 1);
                        s = phase_syms[8*slot +: 8];
                    end
                    // now and then the phase ends with a sequence left open
                    l = (i == len - 1) && !((q == seqs - 1) && ($urandom_range(6) == 0));
                    send_symbol(s, l);
                    random_items++;
                end
            end
            drain();
            calm = 1'b0;
            phase_no++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
